/* rtl/sgp_pkg.sv */
// ----------------------------------------------------------------------------
// sgp_pkg: sign product segment tree package
// Sign codes, operation codes, the node product and the result word shared by
// the tree walker and the top level.
// ----------------------------------------------------------------------------
package sgp_pkg;

    typedef logic [1:0] t_sign;

    localparam t_sign SIGN_POS  = 2'b01;
    localparam t_sign SIGN_NEG  = 2'b11;
    localparam t_sign SIGN_ZERO = 2'b00;

    typedef logic [1:0] t_op;

    localparam t_op OP_CHANGE = 2'd0;
    localparam t_op OP_QUERY  = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic  vld;
        t_sign sign;
    } t_res;

    function automatic t_sign sign_mul(input t_sign a, input t_sign b);
        t_sign r;
        if ((a == SIGN_ZERO) || (b == SIGN_ZERO)) begin
            r = SIGN_ZERO;
        end else if (a[1] ^ b[1]) begin
            r = SIGN_NEG;
        end else begin
            r = SIGN_POS;
        end
        return r;
    endfunction

    function automatic t_sign sign_of16(input logic signed [15:0] v);
        t_sign r;
        if (v == 16'sd0) begin
            r = SIGN_ZERO;
        end else if (v[15]) begin
            r = SIGN_NEG;
        end else begin
            r = SIGN_POS;
        end
        return r;
    endfunction

endpackage

/* rtl/sign_product_segment_tree.sv */
// ----------------------------------------------------------------------------
// sign_product_segment_tree: sign product segment tree
// Binary tree of node signs with leaf change, range sign product and clear.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   in       | i_in_valid / o_in_stall    | operation, element_index, new_value,
//            |                            | range_first, range_last
//   out      | o_out_valid / i_out_stall  | product_sign (query only)
//
// one word at a time: o_in_stall stays high until the operation is done
// change: one leaf write, then one parent rebuild per level up to the root
// query: a range walk up the tree, reading at most two nodes per level
// clear, and the pass after reset: every node set positive, o_in_stall high
// a query result waits in the output register while i_out_stall is high
// ----------------------------------------------------------------------------
module sign_product_segment_tree #(
    parameter int LEAVES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [9:0]         i_element_index,
    input  logic signed [15:0] i_new_value,
    input  logic [9:0]         i_range_first,
    input  logic [9:0]         i_range_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [1:0]  o_product_sign
);

    localparam int NODES  = 2 * LEAVES;
    localparam int NODE_W = $clog2(NODES);

    logic              busy;
    sgp_pkg::t_res     res;
    logic              we;
    logic [NODE_W-1:0] waddr;
    sgp_pkg::t_sign    wdata;
    logic [NODE_W-1:0] raddr;
    sgp_pkg::t_sign    rdata;

    logic              r_out_valid;
    sgp_pkg::t_sign    r_out_sign;

    sgp_walker #(
        .LEAVES (LEAVES),
        .NODE_W (NODE_W)
    ) u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_in_valid && !busy),
        .i_operation     (i_operation),
        .i_element_index (i_element_index),
        .i_new_value     (i_new_value),
        .i_range_first   (i_range_first),
        .i_range_last    (i_range_last),
        .i_out_busy      (r_out_valid && i_out_stall),
        .o_busy          (busy),
        .o_res           (res),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_raddr         (raddr),
        .i_rdata         (rdata)
    );

    sgp_node_ram #(
        .DEPTH (NODES),
        .AW    (NODE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.vld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.vld) begin
            r_out_sign <= res.sign;
        end
    end

    assign o_in_stall     = busy;
    assign o_out_valid    = r_out_valid;
    assign o_product_sign = r_out_sign;

endmodule

/* rtl/sgp_node_ram.sv */
// ----------------------------------------------------------------------------
// sgp_node_ram: tree node store
// One write port and one read port with registered read data; holds the sign
// of every tree node.
// ----------------------------------------------------------------------------
module sgp_node_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  sgp_pkg::t_sign i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output sgp_pkg::t_sign o_rdata
);

    sgp_pkg::t_sign r_mem [DEPTH];
    sgp_pkg::t_sign r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sgp_walker.sv */
// ----------------------------------------------------------------------------
// sgp_walker: tree walk sequencer
// Walks the tree through the shared sign product, one operation at a time:
// leaf write and ancestor rebuild, range product walk, and clearing sweep.
// ----------------------------------------------------------------------------
module sgp_walker #(
    parameter int LEAVES = 1024,
    parameter int NODE_W = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sgp_pkg::t_op       i_operation,
    input  logic [9:0]         i_element_index,
    input  logic signed [15:0] i_new_value,
    input  logic [9:0]         i_range_first,
    input  logic [9:0]         i_range_last,
    input  logic               i_out_busy,
    output logic               o_busy,
    output sgp_pkg::t_res      o_res,
    output logic               o_we,
    output logic [NODE_W-1:0]  o_waddr,
    output sgp_pkg::t_sign     o_wdata,
    output logic [NODE_W-1:0]  o_raddr,
    input  sgp_pkg::t_sign     i_rdata
);

    localparam int          LW       = NODE_W + 1;
    localparam logic [31:0] LEAVES_W = 32'(LEAVES);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(2 * LEAVES - 1);
    localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_UP    = 6'b000010,
        S_QRY   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_CLR   = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [NODE_W-1:0] r_node, n_node;
    sgp_pkg::t_sign    r_val, n_val;
    logic [LW-1:0]     r_lo, n_lo;
    logic [LW-1:0]     r_hi, n_hi;
    logic              r_phase, n_phase;
    logic              r_pend, n_pend;
    sgp_pkg::t_sign    r_acc, n_acc;
    logic [NODE_W-1:0] r_cnt, n_cnt;

    always_comb begin
        logic [NODE_W-1:0] leaf;
        logic [NODE_W-1:0] parent;
        sgp_pkg::t_sign    pv;
        logic [31:0]       first32;
        logic [31:0]       last32;
        logic [LW-1:0]     hi_t;

        n_state = r_state;
        n_node  = r_node;
        n_val   = r_val;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_phase = r_phase;
        n_pend  = 1'b0;
        n_cnt   = r_cnt;
        n_acc   = r_pend ? sgp_pkg::sign_mul(r_acc, i_rdata) : r_acc;
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = sgp_pkg::SIGN_POS;
        o_raddr = '0;
        o_res   = '0;

        leaf    = NODE_W'(32'(i_element_index) + LEAVES_W);
        parent  = {1'b0, r_node[NODE_W-1:1]};
        pv      = sgp_pkg::sign_mul(r_val, i_rdata);
        first32 = 32'(i_range_first);
        last32  = (32'(i_range_last) >= LEAVES_W) ? (LEAVES_W - 32'd1) : 32'(i_range_last);
        hi_t    = r_hi;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_operation)
                        sgp_pkg::OP_CHANGE: begin
                            if (32'(i_element_index) < LEAVES_W) begin
                                o_we    = 1'b1;
                                o_waddr = leaf;
                                o_wdata = sgp_pkg::sign_of16(i_new_value);
                                o_raddr = leaf ^ ROOT;
                                n_node  = leaf;
                                n_val   = sgp_pkg::sign_of16(i_new_value);
                                n_state = S_UP;
                            end
                        end
                        sgp_pkg::OP_QUERY: begin
                            if (first32 > last32) begin
                                n_lo = '0;
                                n_hi = '0;
                            end else begin
                                n_lo = LW'(first32 + LEAVES_W);
                                n_hi = LW'(last32 + LEAVES_W + 32'd1);
                            end
                            n_phase = 1'b0;
                            n_acc   = sgp_pkg::SIGN_POS;
                            n_state = S_QRY;
                        end
                        sgp_pkg::OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UP: begin
                o_we    = 1'b1;
                o_waddr = parent;
                o_wdata = pv;
                if (parent == ROOT) begin
                    n_state = S_IDLE;
                end else begin
                    n_node  = parent;
                    n_val   = pv;
                    o_raddr = parent ^ ROOT;
                end
            end
            S_QRY: begin
                if (!r_phase) begin
                    if (r_lo < r_hi) begin
                        if (r_lo[0]) begin
                            o_raddr = r_lo[NODE_W-1:0];
                            n_pend  = 1'b1;
                            n_lo    = r_lo + LW'(1);
                        end
                        n_phase = 1'b1;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    if (r_hi[0]) begin
                        hi_t    = r_hi - LW'(1);
                        o_raddr = hi_t[NODE_W-1:0];
                        n_pend  = 1'b1;
                    end
                    n_lo    = r_lo >> 1;
                    n_hi    = hi_t >> 1;
                    n_phase = 1'b0;
                end
            end
            S_DRAIN: begin
                if (!r_pend && !i_out_busy) begin
                    o_res.vld  = 1'b1;
                    o_res.sign = r_acc;
                    n_state    = S_IDLE;
                end
            end
            S_CLR: begin
                o_we    = 1'b1;
                o_waddr = r_cnt;
                o_wdata = sgp_pkg::SIGN_POS;
                n_cnt   = r_cnt + NODE_W'(1);
                if (r_cnt == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_val  <= n_val;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_acc  <= n_acc;
    end

`ifndef SYNTHESIS
    // reset always starts the clearing sweep from node zero
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLR) && (r_cnt == '0))
        else $error("reset did not start the clearing sweep");

    // the rebuild never stands on the root
    a_up_below_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> (r_node > ROOT))
        else $error("rebuild walk reached the root");

    // range walk bounds never cross
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRY) |-> (r_lo <= r_hi))
        else $error("range walk bounds crossed");

    // a result word leaves only after the last node read is folded in
    a_res_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.vld |-> (r_state == S_DRAIN) && !r_pend && (r_acc != 2'b10))
        else $error("result word before accumulation settled");
`endif

endmodule
